// ----- rtl/npc_pkg.sv -----
// npc_pkg: shared constants, control structs and the component clip function
// for the nearest palette colour search block
// no dependencies
package npc_pkg;

	// palette geometry
	localparam int PALETTE_DEPTH  = 256;
	localparam int COMPONENT_BITS = 8;

	// fixed field widths
	localparam int IN_W    = 16;
	localparam int SLOT_W  = 8;
	localparam int OUT_W   = 8;
	localparam int COUNT_W = 9;

	// derived widths
	localparam int IDX_W   = $clog2(PALETTE_DEPTH);
	localparam int CNT_W   = $clog2(PALETTE_DEPTH + 1);
	localparam int ENTRY_W = 3 * COMPONENT_BITS;
	localparam int SQ_W    = 2 * COMPONENT_BITS;
	localparam int DIST_W  = 2 * COMPONENT_BITS + 3;

	// channel weights
	localparam int RED_WEIGHT   = 2;
	localparam int GREEN_WEIGHT = 4;
	localparam int BLUE_WEIGHT  = 1;

	// register reset value
	localparam int COUNT_RESET = 256;

	// op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [COMPONENT_BITS-1:0] comp_t;

	// palette cell control, common to every cell
	typedef struct packed {
		logic shift;
		logic wr;
	} npc_cell_ctl_t;

	// feed from the ring head into the distance pipeline
	typedef struct packed {
		logic             clear;
		logic             valid;
		logic [IDX_W-1:0] idx;
	} npc_feed_t;

	// clip a signed component to 0 .. 2^COMPONENT_BITS-1
	function automatic comp_t clip_comp(input logic signed [IN_W-1:0] v);
		comp_t res;
		if (v < 0) begin
			res = '0;
		end else if (v > IN_W'((1 << COMPONENT_BITS) - 1)) begin
			res = '1;
		end else begin
			res = v[COMPONENT_BITS-1:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/npc_if.sv -----
// npc_in_if / npc_out_if: valid-ready channels for input items and results
// depends on npc_pkg for field widths
interface npc_in_if;
	logic                               valid;
	logic                               ready;
	logic                               op;
	logic [npc_pkg::SLOT_W-1:0]         entry_index;
	logic signed [npc_pkg::IN_W-1:0]    red_in;
	logic signed [npc_pkg::IN_W-1:0]    green_in;
	logic signed [npc_pkg::IN_W-1:0]    blue_in;

	modport source (output valid, op, entry_index, red_in, green_in, blue_in, input ready);
	modport sink (input valid, op, entry_index, red_in, green_in, blue_in, output ready);
endinterface

interface npc_out_if;
	logic                       valid;
	logic                       ready;
	logic [npc_pkg::OUT_W-1:0]  nearest_index;

	modport source (output valid, nearest_index, input ready);
	modport sink (input valid, nearest_index, output ready);
endinterface

// ----- rtl/npc_cell.sv -----
// npc_cell: one palette entry of the rotating palette ring
// depends on npc_pkg
module npc_cell (
	input  logic                         clk,
	input  npc_pkg::npc_cell_ctl_t       ctl,
	input  logic                         sel,
	input  logic [npc_pkg::ENTRY_W-1:0]  wr_data,
	input  logic [npc_pkg::ENTRY_W-1:0]  nbr_data,
	output logic [npc_pkg::ENTRY_W-1:0]  data_q
);
	import npc_pkg::*;

	// write from the input channel, or take the neighbor's entry during a scan
	always_ff @(posedge clk) begin
		if (ctl.wr && sel) begin
			data_q <= wr_data;
		end else if (ctl.shift) begin
			data_q <= nbr_data;
		end
	end

endmodule

// ----- rtl/npc_dist.sv -----
// npc_dist: weighted squared distance pipeline and running minimum
// depends on npc_pkg
module npc_dist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  npc_pkg::npc_feed_t           feed,
	input  logic [npc_pkg::ENTRY_W-1:0]  entry,
	input  npc_pkg::comp_t               q_red,
	input  npc_pkg::comp_t               q_green,
	input  npc_pkg::comp_t               q_blue,
	output logic [npc_pkg::IDX_W-1:0]    best_idx_q
);
	import npc_pkg::*;

	comp_t              e_red, e_green, e_blue;
	logic               v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]   idx_s1, idx_s2, idx_s3;
	comp_t              dr_s1, dg_s1, db_s1;
	logic [SQ_W-1:0]    sr_s2, sg_s2, sb_s2;
	logic [DIST_W-1:0]  dist_s3;
	logic [DIST_W-1:0]  best_dist_q;
	logic               have_q;

	assign e_red   = entry[3*COMPONENT_BITS-1:2*COMPONENT_BITS];
	assign e_green = entry[2*COMPONENT_BITS-1:COMPONENT_BITS];
	assign e_blue  = entry[COMPONENT_BITS-1:0];

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= feed.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// absolute differences, squares, weighted sum
	always_ff @(posedge clk) begin
		idx_s1  <= feed.idx;
		dr_s1   <= (e_red > q_red) ? e_red - q_red : q_red - e_red;
		dg_s1   <= (e_green > q_green) ? e_green - q_green : q_green - e_green;
		db_s1   <= (e_blue > q_blue) ? e_blue - q_blue : q_blue - e_blue;
		idx_s2  <= idx_s1;
		sr_s2   <= SQ_W'(dr_s1) * SQ_W'(dr_s1);
		sg_s2   <= SQ_W'(dg_s1) * SQ_W'(dg_s1);
		sb_s2   <= SQ_W'(db_s1) * SQ_W'(db_s1);
		idx_s3  <= idx_s2;
		dist_s3 <= DIST_W'(RED_WEIGHT) * DIST_W'(sr_s2)
		         + DIST_W'(GREEN_WEIGHT) * DIST_W'(sg_s2)
		         + DIST_W'(BLUE_WEIGHT) * DIST_W'(sb_s2);
	end

	// running minimum, first entry wins on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_idx_q <= '0;
		end else if (feed.clear) begin
			have_q     <= 1'b0;
			best_idx_q <= '0;
		end else if (v_s3 && (!have_q || dist_s3 < best_dist_q)) begin
			have_q     <= 1'b1;
			best_idx_q <= idx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && (!have_q || dist_s3 < best_dist_q)) begin
			best_dist_q <= dist_s3;
		end
	end

endmodule

// ----- rtl/nearest_palette_colour_search.sv -----
// nearest_palette_colour_search: palette ring of cells, scan control and result register
// depends on npc_pkg, npc_if, npc_cell, npc_dist
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    op, entry_index, red_in, green_in, blue_in
//  out_ch    out  valid / ready    nearest_index
//  cfg       in   cfg_we           cfg_wdata (entries_in_use)
//
// a write leaves the input open; a query scans the whole palette ring, which rotates one
// entry per cycle past the head cell, then drains three distance stages
// reset clears control and sets entries_in_use to 256; palette contents are undefined
// until written
// the result sits in an output register; a finished query waits there only if the
// previous result has not been taken, and the input stays closed meanwhile
module nearest_palette_colour_search (
	input  logic                         clk,
	input  logic                         arst_n,
	npc_in_if.sink                       in_ch,
	npc_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [npc_pkg::COUNT_W-1:0]  cfg_wdata
);
	import npc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] entries_in_use_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   k_q;
	logic [1:0]         drain_q;
	comp_t              qr_q, qg_q, qb_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_idx_q;

	logic               in_xfer;
	logic               wr_xfer;
	logic               query_xfer;
	logic               load_out;
	logic [ENTRY_W-1:0] wr_data;
	npc_cell_ctl_t      cell_ctl;
	npc_feed_t          feed;
	logic [ENTRY_W-1:0] ring [PALETTE_DEPTH];
	logic [IDX_W-1:0]   best_idx;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign wr_xfer     = in_xfer && (in_ch.op == OP_WRITE)
	                     && (int'(in_ch.entry_index) < PALETTE_DEPTH);
	assign query_xfer  = in_xfer && (in_ch.op == OP_QUERY);
	assign load_out    = (state_q == ST_FINISH) && (!out_valid_q || out_ch.ready);

	assign wr_data = {clip_comp(in_ch.red_in), clip_comp(in_ch.green_in),
	                  clip_comp(in_ch.blue_in)};

	// ring control
	assign cell_ctl.wr    = wr_xfer;
	assign cell_ctl.shift = (state_q == ST_SCAN);

	// palette ring: each cell takes its upper neighbor, the top wraps to the head
	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		npc_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.sel      (int'(in_ch.entry_index) == i),
			.wr_data  (wr_data),
			.nbr_data (ring[(i + 1) % PALETTE_DEPTH]),
			.data_q   (ring[i])
		);
	end

	// head entry into the distance pipeline
	assign feed.clear = query_xfer;
	assign feed.valid = (state_q == ST_SCAN) && (CNT_W'(k_q) < count_q);
	assign feed.idx   = k_q;

	npc_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.entry      (ring[0]),
		.q_red      (qr_q),
		.q_green    (qg_q),
		.q_blue     (qb_q),
		.best_idx_q (best_idx)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= COUNT_W'(COUNT_RESET);
		end else if (cfg_we) begin
			entries_in_use_q <= cfg_wdata;
		end
	end

	// query colour and saturated entry count
	always_ff @(posedge clk) begin
		if (query_xfer) begin
			qr_q    <= clip_comp(in_ch.red_in);
			qg_q    <= clip_comp(in_ch.green_in);
			qb_q    <= clip_comp(in_ch.blue_in);
			count_q <= (int'(entries_in_use_q) > PALETTE_DEPTH) ?
			           CNT_W'(PALETTE_DEPTH) : CNT_W'(entries_in_use_q);
		end
	end

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q     <= '0;
					drain_q <= '0;
					if (query_xfer) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					k_q <= k_q + 1'b1;
					if (k_q == IDX_W'(PALETTE_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q <= OUT_W'(best_idx);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.nearest_index = out_idx_q;

endmodule

// ----- rtl/npc_checker.sv -----
// npc_checker: port-level checks on the nearest palette colour search
// bound to nearest_palette_colour_search; no package dependency
module npc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_op,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_index
);

	// a result held back stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its index
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_index))
		else $error("result changed while stalled");

	// a query transfer closes the input
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op |=> !in_ready)
		else $error("input open right after a query");

	// a palette write never blocks the next item
	a_write_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_op |=> in_ready)
		else $error("input closed after a write");

	// a new result appears only as the block returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while busy");

endmodule

bind nearest_palette_colour_search npc_checker u_npc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.op),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_index (out_ch.nearest_index)
);

// ----- sim/tb_nearest_palette_colour_search.sv -----
// tb_nearest_palette_colour_search: self-checking bench for the nearest palette colour search
// depends on npc_pkg, npc_in_if / npc_out_if and the nearest_palette_colour_search rtl
// a local palette copy predicts each query; results are checked in order against a queue
module tb_nearest_palette_colour_search;
	import npc_pkg::*;

	localparam int          COMP_TOP      = (1 << COMPONENT_BITS) - 1;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          DRAIN_CYCLES  = 300;
	localparam int unsigned CYCLE_LIMIT   = 4_000_000;
	localparam int          PHASE_ITEMS   = 165;

	typedef struct packed {
		comp_t r;
		comp_t g;
		comp_t b;
	} colour_t;

	typedef struct packed {
		logic                     op;
		logic [SLOT_W-1:0]        slot;
		logic signed [IN_W-1:0]   red;
		logic signed [IN_W-1:0]   green;
		logic signed [IN_W-1:0]   blue;
	} search_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [COUNT_W-1:0]   cfg_wdata;

	npc_in_if  in_ch();
	npc_out_if out_ch();

	nearest_palette_colour_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// local copy of the palette and the search count
	colour_t              palette_model [PALETTE_DEPTH];
	logic [COUNT_W-1:0]   entry_count;
	logic [OUT_W-1:0]     pending_nearest [$];
	logic [OUT_W-1:0]     want_index;
	int                   fail_count;
	int unsigned          cycle_count;
	logic                 steady_flow;

	// clock
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// clip a signed component to the stored range
	function automatic comp_t clamp_component(logic signed [IN_W-1:0] v);
		if (v < 0)
			return '0;
		if (v > COMP_TOP)
			return '1;
		return v[COMPONENT_BITS-1:0];
	endfunction

	function automatic int unsigned searched_entries();
		return (entry_count > PALETTE_DEPTH) ? PALETTE_DEPTH : entry_count;
	endfunction

	function automatic int unsigned weighted_distance(colour_t a, colour_t b);
		int dr, dg, db;
		dr = int'(a.r) - int'(b.r);
		dg = int'(a.g) - int'(b.g);
		db = int'(a.b) - int'(b.b);
		return RED_WEIGHT * dr * dr + GREEN_WEIGHT * dg * dg + BLUE_WEIGHT * db * db;
	endfunction

	// first entry with the least weighted distance; zero when nothing is searched
	function automatic logic [OUT_W-1:0] predict_nearest(colour_t q);
		int unsigned best, best_dist, cand_dist;
		best = 0;
		best_dist = 0;
		for (int unsigned i = 0; i < searched_entries(); i++) begin
			cand_dist = weighted_distance(palette_model[i], q);
			if (i == 0 || cand_dist < best_dist) begin
				best = i;
				best_dist = cand_dist;
			end
		end
		return best[OUT_W-1:0];
	endfunction

	// update the palette copy or queue the expected index for one accepted item
	function automatic void track_item(search_item_t item);
		colour_t c;
		c = '{clamp_component(item.red), clamp_component(item.green),
			clamp_component(item.blue)};
		if (item.op == OP_WRITE) begin
			palette_model[item.slot] = c;
		end else begin
			pending_nearest.push_back(predict_nearest(c));
		end
	endfunction

	function automatic search_item_t make_item(logic op, logic [SLOT_W-1:0] slot,
			logic signed [IN_W-1:0] r, logic signed [IN_W-1:0] g,
			logic signed [IN_W-1:0] b);
		search_item_t item;
		item.op = op;
		item.slot = slot;
		item.red = r;
		item.green = g;
		item.blue = b;
		return item;
	endfunction

	// mostly in range, some full 16-bit values, some clip edges
	function automatic logic signed [IN_W-1:0] pick_component();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 75)
			return IN_W'($urandom_range(0, COMP_TOP));
		if (sel < 88)
			return IN_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'shFFFF;
			2: return 16'sh0000;
			3: return IN_W'(COMP_TOP);
			4: return IN_W'(COMP_TOP + 1);
			default: return 16'sh7FFF;
		endcase
	endfunction

	function automatic logic signed [IN_W-1:0] nudge(comp_t c, int spread);
		return IN_W'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// random write or query; some sit on or next to a searched entry to force close calls
	function automatic search_item_t random_item();
		search_item_t item;
		int unsigned pick;
		int spread;
		item.op = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_WRITE;
		item.slot = SLOT_W'($urandom_range(0, PALETTE_DEPTH - 1));
		item.red = pick_component();
		item.green = pick_component();
		item.blue = pick_component();
		if (searched_entries() != 0 && $urandom_range(0, 99) < 35) begin
			pick = $urandom_range(0, searched_entries() - 1);
			spread = (item.op == OP_QUERY) ? 3 : 0;
			item.red = nudge(palette_model[pick].r, spread);
			item.green = nudge(palette_model[pick].g, spread);
			item.blue = nudge(palette_model[pick].b, spread);
		end
		return item;
	endfunction

	// drive one item and hold it until the transfer
	task automatic send_item(search_item_t item);
		if (!steady_flow) begin
			while ($urandom_range(0, 99) < 30) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= item.op;
		in_ch.entry_index <= item.slot;
		in_ch.red_in <= item.red;
		in_ch.green_in <= item.green;
		in_ch.blue_in <= item.blue;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		track_item(item);
	endtask

	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		while (pending_nearest.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only once the block has gone idle
	task automatic set_entry_count(logic [COUNT_W-1:0] value);
		wait_for_results();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		entry_count = value;
	endtask

	task automatic run_random_phase(logic [COUNT_W-1:0] count, int n_items);
		set_entry_count(count);
		repeat (n_items)
			send_item(random_item());
	endtask

	// small palette: clipping on writes and queries, channel weights, tie to lowest index
	task automatic test_clip_weights_ties();
		set_entry_count(4);
		send_item(make_item(OP_WRITE, 0, -32768, -1, -200));
		send_item(make_item(OP_WRITE, 1, 32767, 256, 255));
		send_item(make_item(OP_WRITE, 2, 100, 50, 200));
		send_item(make_item(OP_WRITE, 3, 100, 50, 200));
		send_item(make_item(OP_QUERY, 0, -1, -1, -1));
		send_item(make_item(OP_QUERY, 8'hFF, 32767, 300, 1000));
		send_item(make_item(OP_QUERY, 8'h55, 100, 50, 200));
		send_item(make_item(OP_QUERY, 8'hAA, 128, 128, 128));
		// red 20 against blue 25: weights pick the blue entry
		send_item(make_item(OP_WRITE, 0, 20, 0, 0));
		send_item(make_item(OP_WRITE, 1, 0, 0, 25));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
		// green 10 against blue 25
		send_item(make_item(OP_WRITE, 0, 0, 10, 0));
		send_item(make_item(OP_QUERY, 0, 0, 0, 0));
	endtask

	// zero entries searched, then a single entry
	task automatic test_search_count_edges();
		set_entry_count(0);
		send_item(make_item(OP_QUERY, 0, 7, 7, 7));
		send_item(make_item(OP_QUERY, 8'hAA, -5, 300, 128));
		set_entry_count(1);
		send_item(make_item(OP_QUERY, 0, 255, 255, 255));
		send_item(make_item(OP_QUERY, 8'hFF, 0, 0, 0));
	endtask

	// write every slot so any search count is legal from here on
	task automatic test_fill_palette();
		for (int i = 0; i < PALETTE_DEPTH; i++)
			send_item(make_item(OP_WRITE, SLOT_W'(i), pick_component(), pick_component(),
				pick_component()));
	endtask

	task automatic test_random_search();
		run_random_phase(COUNT_W'(COUNT_RESET), PHASE_ITEMS);
		run_random_phase(9'h1FF, PHASE_ITEMS);
		run_random_phase(0, PHASE_ITEMS / 3);
		run_random_phase(1, PHASE_ITEMS);
		run_random_phase(2, PHASE_ITEMS);
		run_random_phase(COUNT_W'(PALETTE_DEPTH - 1), PHASE_ITEMS);
		run_random_phase(COUNT_W'($urandom_range(3, PALETTE_DEPTH - 2)), PHASE_ITEMS);
		run_random_phase(COUNT_W'($urandom_range(PALETTE_DEPTH + 1, 510)), PHASE_ITEMS);
		run_random_phase(COUNT_W'($urandom_range(1, PALETTE_DEPTH)), PHASE_ITEMS);
	endtask

	// back-to-back traffic with the output always ready
	task automatic test_unbroken_stream();
		set_entry_count(COUNT_W'(COUNT_RESET));
		steady_flow = 1'b1;
		repeat (PHASE_ITEMS)
			send_item(random_item());
		wait_for_results();
		steady_flow = 1'b0;
	endtask

	// result check and output stalls
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (pending_nearest.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d",
					$time, out_ch.nearest_index);
				fail_count++;
			end else begin
				want_index = pending_nearest.pop_front();
				if (out_ch.nearest_index !== want_index) begin
					$display("%0t: nearest_index mismatch, expected %0d, actual %0d",
						$time, want_index, out_ch.nearest_index);
					fail_count++;
				end
			end
		end
		out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 30);
	end

	// test sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_WRITE;
		in_ch.entry_index = '0;
		in_ch.red_in = '0;
		in_ch.green_in = '0;
		in_ch.blue_in = '0;
		out_ch.ready = 1'b0;
		entry_count = COUNT_W'(COUNT_RESET);
		fail_count = 0;
		cycle_count = 0;
		steady_flow = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clip_weights_ties();
		test_search_count_edges();
		test_fill_palette();
		test_random_search();
		test_unbroken_stream();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_nearest.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
